@@ sv/chi2d_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and width helpers for the 2-d hermite interpolator
// no dependencies
package chi2d_pkg;

    localparam int DATA_W    = 32;
    localparam int TS_W      = 16;
    localparam int TS_SHIFT  = 16;
    localparam int WS_FRAC   = 16;
    localparam int IN_FIELDS = 9;
    localparam int CFG_IDX_W = 2;

    localparam int NUM_STAGES = 9;
    localparam int ST_ALPHA   = 0;
    localparam int ST_CLAMP   = 1;
    localparam int ST_SQ      = 2;
    localparam int ST_CUBE    = 3;
    localparam int ST_BASIS   = 4;
    localparam int ST_TERM    = 5;
    localparam int ST_SUM     = 6;
    localparam int ST_PART    = 7;
    localparam int ST_OUT     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA_RATE    = 2'd0,
        CFG_TANGENT_SCALE = 2'd1,
        CFG_WORLD_SCALE   = 2'd2
    } t_cfg_idx;

    localparam logic [DATA_W-1:0] ALPHA_RATE_RST    = 32'd85899;
    localparam logic [TS_W-1:0]   TANGENT_SCALE_RST = 16'd3277;
    localparam logic [DATA_W-1:0] WORLD_SCALE_RST   = 32'd65536;

    typedef struct packed {
        logic [DATA_W-1:0] alpha_rate;
        logic [TS_W-1:0]   tangent_scale;
        logic [DATA_W-1:0] world_scale;
    } t_cfg;

    typedef logic [NUM_STAGES-1:0] t_stage_en;
    typedef logic signed [DATA_W-1:0] t_word;

    // width of the signed basis weights
    function automatic int basis_w(input int frac);
        return frac + 4;
    endfunction

    // width of the blended position after the fraction is dropped
    function automatic int pos_w(input int frac);
        return DATA_W + basis_w(frac) + 2 - frac;
    endfunction

endpackage

@@ sv/chi2d_basis.sv @@
`timescale 1ns / 1ps
// alpha from elapsed time, clamp, powers and hermite basis weights (stages 0 to 4)
// depends on chi2d_pkg
module chi2d_basis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                     i_clk,
    input  chi2d_pkg::t_stage_en                     i_ld,
    input  logic [chi2d_pkg::DATA_W-1:0]             i_elapsed,
    input  logic [chi2d_pkg::DATA_W-1:0]             i_alpha_rate,
    output logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] o_h00,
    output logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] o_h10,
    output logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] o_h01,
    output logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] o_h11,
    output logic                                     o_ext
);
    import chi2d_pkg::*;

    localparam int TW        = FRAC_BITS + 1;
    localparam int SW        = FRAC_BITS + 2;
    localparam int HW        = basis_w(FRAC_BITS);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SQ_FULL_W = 2 * TW;
    localparam int CU_FULL_W = SW + TW;
    localparam logic [TW-1:0] T_LIM = TW'(3) << (FRAC_BITS - 1);
    localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;
    localparam logic signed [HW-1:0] H_ONE = HW'(1) << FRAC_BITS;

    logic [PROD_W-1:0]    n_prod_s0, r_prod_s0;
    logic [PROD_W-1:0]    w_t_raw;
    logic [TW-1:0]        n_t_s1, r_t_s1, r_t_s2, r_t_s3;
    logic                 n_ext_s1, r_ext_s1, r_ext_s2, r_ext_s3, r_ext_s4;
    logic [SQ_FULL_W-1:0] n_sq_full;
    logic [SW-1:0]        n_sq_s2, r_sq_s2, r_sq_s3;
    logic [CU_FULL_W-1:0] n_cu_full;
    logic [SW-1:0]        n_cu_s3, r_cu_s3;
    logic signed [HW-1:0] w_t, w_sq, w_cu;
    logic signed [HW-1:0] n_h00, n_h10, n_h01, n_h11;
    logic signed [HW-1:0] r_h00, r_h10, r_h01, r_h11;

    always_comb begin
        n_prod_s0 = PROD_W'(i_elapsed) * PROD_W'(i_alpha_rate);

        w_t_raw  = r_prod_s0 >> (DATA_W - FRAC_BITS);
        n_t_s1   = (w_t_raw > PROD_W'(T_LIM)) ? T_LIM : w_t_raw[TW-1:0];
        n_ext_s1 = w_t_raw > PROD_W'(T_ONE);

        n_sq_full = SQ_FULL_W'(r_t_s1) * SQ_FULL_W'(r_t_s1);
        n_sq_s2   = n_sq_full[FRAC_BITS +: SW];

        n_cu_full = CU_FULL_W'(r_sq_s2) * CU_FULL_W'(r_t_s2);
        n_cu_s3   = n_cu_full[FRAC_BITS +: SW];

        w_t   = $signed(HW'(r_t_s3));
        w_sq  = $signed(HW'(r_sq_s3));
        w_cu  = $signed(HW'(r_cu_s3));
        n_h00 = (w_cu <<< 1) - (w_sq <<< 1) - w_sq + H_ONE;
        n_h10 = w_cu - (w_sq <<< 1) + w_t;
        n_h01 = (w_sq <<< 1) + w_sq - (w_cu <<< 1);
        n_h11 = w_cu - w_sq;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_ALPHA]) begin
            r_prod_s0 <= n_prod_s0;
        end
        if (i_ld[ST_CLAMP]) begin
            r_t_s1   <= n_t_s1;
            r_ext_s1 <= n_ext_s1;
        end
        if (i_ld[ST_SQ]) begin
            r_t_s2   <= r_t_s1;
            r_sq_s2  <= n_sq_s2;
            r_ext_s2 <= r_ext_s1;
        end
        if (i_ld[ST_CUBE]) begin
            r_t_s3   <= r_t_s2;
            r_sq_s3  <= r_sq_s2;
            r_cu_s3  <= n_cu_s3;
            r_ext_s3 <= r_ext_s2;
        end
        if (i_ld[ST_BASIS]) begin
            r_h00    <= n_h00;
            r_h10    <= n_h10;
            r_h01    <= n_h01;
            r_h11    <= n_h11;
            r_ext_s4 <= r_ext_s3;
        end
    end

    assign o_h00 = r_h00;
    assign o_h10 = r_h10;
    assign o_h01 = r_h01;
    assign o_h11 = r_h11;
    assign o_ext = r_ext_s4;

endmodule

@@ sv/chi2d_blend.sv @@
`timescale 1ns / 1ps
// tangents, position delay line and weighted sum of the hermite terms (stages 0 to 6)
// depends on chi2d_pkg
module chi2d_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                           i_clk,
    input  chi2d_pkg::t_stage_en                           i_ld,
    input  chi2d_pkg::t_word                               i_pos [4],
    input  chi2d_pkg::t_word                               i_vel [4],
    input  logic [chi2d_pkg::TS_W-1:0]                     i_tangent_scale,
    input  logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] i_h00,
    input  logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] i_h10,
    input  logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] i_h01,
    input  logic signed [chi2d_pkg::basis_w(FRAC_BITS)-1:0] i_h11,
    input  logic                                           i_ext,
    output logic signed [chi2d_pkg::pos_w(FRAC_BITS)-1:0]  o_pos [2],
    output logic                                           o_ext
);
    import chi2d_pkg::*;

    localparam int HW     = basis_w(FRAC_BITS);
    localparam int PW     = pos_w(FRAC_BITS);
    localparam int TP_W   = DATA_W + TS_W + 1;
    localparam int TERM_W = DATA_W + HW;
    localparam int ACC_W  = TERM_W + 2;

    logic signed [TP_W-1:0]   w_tprod [4];
    t_word                    n_tan [4];
    t_word                    r_pos_d [ST_BASIS+1][4];
    t_word                    r_tan_d [ST_BASIS+1][4];
    logic signed [TERM_W-1:0] n_term [2][4];
    logic signed [TERM_W-1:0] r_term [2][4];
    logic signed [ACC_W-1:0]  w_acc [2];
    logic signed [PW-1:0]     n_pos [2];
    logic signed [PW-1:0]     r_pos [2];
    logic                     r_ext_s5, r_ext_s6;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_tprod[j] = TP_W'(i_vel[j]) * TP_W'($signed({1'b0, i_tangent_scale}));
            n_tan[j]   = w_tprod[j][TS_SHIFT +: DATA_W];
        end
        for (int c = 0; c < 2; c++) begin
            n_term[c][0] = TERM_W'(r_pos_d[ST_BASIS][c])     * TERM_W'(i_h00);
            n_term[c][1] = TERM_W'(r_tan_d[ST_BASIS][c])     * TERM_W'(i_h10);
            n_term[c][2] = TERM_W'(r_pos_d[ST_BASIS][2 + c]) * TERM_W'(i_h01);
            n_term[c][3] = TERM_W'(r_tan_d[ST_BASIS][2 + c]) * TERM_W'(i_h11);
            w_acc[c] = ACC_W'(r_term[c][0]) + ACC_W'(r_term[c][1])
                     + ACC_W'(r_term[c][2]) + ACC_W'(r_term[c][3]);
            n_pos[c] = w_acc[c][FRAC_BITS +: PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_ALPHA]) begin
            r_pos_d[ST_ALPHA] <= i_pos;
            r_tan_d[ST_ALPHA] <= n_tan;
        end
        for (int k = ST_ALPHA + 1; k <= ST_BASIS; k++) begin
            if (i_ld[k]) begin
                r_pos_d[k] <= r_pos_d[k-1];
                r_tan_d[k] <= r_tan_d[k-1];
            end
        end
        if (i_ld[ST_TERM]) begin
            r_term   <= n_term;
            r_ext_s5 <= i_ext;
        end
        if (i_ld[ST_SUM]) begin
            r_pos    <= n_pos;
            r_ext_s6 <= r_ext_s5;
        end
    end

    assign o_pos = r_pos;
    assign o_ext = r_ext_s6;

endmodule

@@ sv/chi2d_scale.sv @@
`timescale 1ns / 1ps
// world scaling in two partial products and saturation to 32 bits (stages 7 and 8)
// depends on chi2d_pkg
module chi2d_scale #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          i_clk,
    input  chi2d_pkg::t_stage_en                          i_ld,
    input  logic signed [chi2d_pkg::pos_w(FRAC_BITS)-1:0] i_pos [2],
    input  logic                                          i_ext,
    input  logic [chi2d_pkg::DATA_W-1:0]                  i_world_scale,
    output chi2d_pkg::t_word                              o_x,
    output chi2d_pkg::t_word                              o_y,
    output logic                                          o_ext,
    output logic                                          o_sat
);
    import chi2d_pkg::*;

    localparam int PW    = pos_w(FRAC_BITS);
    localparam int HI_W  = (PW - WS_FRAC) + DATA_W + 1;
    localparam int LO_W  = WS_FRAC + DATA_W;
    localparam int SUM_W = HI_W + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    logic signed [HI_W-1:0]  n_hi [2];
    logic signed [HI_W-1:0]  r_hi [2];
    logic [LO_W-1:0]         n_lo [2];
    logic [LO_W-1:0]         r_lo [2];
    logic signed [SUM_W-1:0] w_q [2];
    logic [1:0]              w_over, w_under;
    t_word                   n_out [2];
    logic                    n_sat;
    logic                    r_ext_s7, r_ext_s8, r_sat;
    t_word                   r_out_x, r_out_y;

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            n_hi[c] = HI_W'($signed(i_pos[c][PW-1:WS_FRAC]))
                    * HI_W'($signed({1'b0, i_world_scale}));
            n_lo[c] = LO_W'(i_pos[c][WS_FRAC-1:0]) * LO_W'(i_world_scale);
            w_q[c]  = SUM_W'(r_hi[c])
                    + SUM_W'($signed({1'b0, r_lo[c][LO_W-1:WS_FRAC]}));
            w_over[c]  = w_q[c] > SAT_HI;
            w_under[c] = w_q[c] < SAT_LO;
            if (w_over[c]) begin
                n_out[c] = SAT_HI[DATA_W-1:0];
            end else if (w_under[c]) begin
                n_out[c] = SAT_LO[DATA_W-1:0];
            end else begin
                n_out[c] = w_q[c][DATA_W-1:0];
            end
        end
        n_sat = |(w_over | w_under);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[ST_PART]) begin
            r_hi     <= n_hi;
            r_lo     <= n_lo;
            r_ext_s7 <= i_ext;
        end
        if (i_ld[ST_OUT]) begin
            r_out_x  <= n_out[0];
            r_out_y  <= n_out[1];
            r_sat    <= n_sat;
            r_ext_s8 <= r_ext_s7;
        end
    end

    assign o_x   = r_out_x;
    assign o_y   = r_out_y;
    assign o_ext = r_ext_s8;
    assign o_sat = r_sat;

endmodule

@@ sv/clamped_cubic_hermite_interp_2d.sv @@
`timescale 1ns / 1ps
// top level: configuration registers, pipeline valid chain and stream ports
// depends on chi2d_pkg, chi2d_basis, chi2d_blend, chi2d_scale
//
// usage
//  - slave stream carries two snapshots (position and velocity, signed q16.16)
//    and the microseconds since the newer one; master stream returns the
//    interpolated, world-scaled and saturated position, flags in tuser
//  - configuration channel writes alpha_rate, tangent_scale and world_scale;
//    o_cfg_ready is always high, writes are expected while the pipeline is empty
//  - nine register stages; a taken item moves through them in order and is valid at the output stage
//  - one item per cycle sustained while the master accepts, set by the 9-stage pipeline with no loop
//  - each stage holds a valid bit; a stage loads when it is empty or the next
//    one moves, so bubbles close up and a stalled master holds the output
//    register while upstream stages keep filling
//  - synchronous active-low reset empties the pipeline and restores the
//    register defaults; the stream payload registers are not reset
module clamped_cubic_hermite_interp_2d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // prev_x, prev_y, prev_vx, prev_vy, latest_x, latest_y, latest_vx, latest_vy, elapsed_us
    input  logic [chi2d_pkg::IN_FIELDS*chi2d_pkg::DATA_W-1:0] i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // out_x, out_y
    output logic [2*chi2d_pkg::DATA_W-1:0]       o_m_tdata,
    // extrapolating, saturated
    output logic [1:0]                           o_m_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [chi2d_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [chi2d_pkg::DATA_W-1:0]         i_cfg_data
);
    import chi2d_pkg::*;

    localparam int HW = basis_w(FRAC_BITS);
    localparam int PW = pos_w(FRAC_BITS);

    t_cfg                  r_cfg;
    logic [NUM_STAGES-1:0] r_vld, n_vld;
    logic [NUM_STAGES:0]   w_rdy;
    t_stage_en             w_ld;

    t_word                 w_pos [4];
    t_word                 w_vel [4];
    logic signed [HW-1:0]  w_h00, w_h10, w_h01, w_h11;
    logic                  w_ext_basis, w_ext_blend, w_ext_out, w_sat_out;
    logic signed [PW-1:0]  w_blend_pos [2];
    t_word                 w_out_x, w_out_y;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha_rate    <= ALPHA_RATE_RST;
            r_cfg.tangent_scale <= TANGENT_SCALE_RST;
            r_cfg.world_scale   <= WORLD_SCALE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ALPHA_RATE: begin
                    r_cfg.alpha_rate <= i_cfg_data;
                end
                CFG_TANGENT_SCALE: begin
                    r_cfg.tangent_scale <= i_cfg_data[TS_W-1:0];
                end
                CFG_WORLD_SCALE: begin
                    r_cfg.world_scale <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // per-stage ready and valid chain
    assign w_rdy[NUM_STAGES] = i_m_tready;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_comb begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = (k == 0) ? i_s_tvalid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_ld       = w_rdy[NUM_STAGES-1:0];
    assign o_s_tready = w_rdy[0];
    assign o_m_tvalid = r_vld[ST_OUT];

    // item unpacking
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            w_pos[c]     = i_s_tdata[c*DATA_W +: DATA_W];
            w_vel[c]     = i_s_tdata[(2 + c)*DATA_W +: DATA_W];
            w_pos[2 + c] = i_s_tdata[(4 + c)*DATA_W +: DATA_W];
            w_vel[2 + c] = i_s_tdata[(6 + c)*DATA_W +: DATA_W];
        end
    end

    chi2d_basis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_basis (
        .i_clk        (i_clk),
        .i_ld         (w_ld),
        .i_elapsed    (i_s_tdata[8*DATA_W +: DATA_W]),
        .i_alpha_rate (r_cfg.alpha_rate),
        .o_h00        (w_h00),
        .o_h10        (w_h10),
        .o_h01        (w_h01),
        .o_h11        (w_h11),
        .o_ext        (w_ext_basis)
    );

    chi2d_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk           (i_clk),
        .i_ld            (w_ld),
        .i_pos           (w_pos),
        .i_vel           (w_vel),
        .i_tangent_scale (r_cfg.tangent_scale),
        .i_h00           (w_h00),
        .i_h10           (w_h10),
        .i_h01           (w_h01),
        .i_h11           (w_h11),
        .i_ext           (w_ext_basis),
        .o_pos           (w_blend_pos),
        .o_ext           (w_ext_blend)
    );

    chi2d_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk         (i_clk),
        .i_ld          (w_ld),
        .i_pos         (w_blend_pos),
        .i_ext         (w_ext_blend),
        .i_world_scale (r_cfg.world_scale),
        .o_x           (w_out_x),
        .o_y           (w_out_y),
        .o_ext         (w_ext_out),
        .o_sat         (w_sat_out)
    );

    assign o_m_tdata = {w_out_y, w_out_x};
    assign o_m_tuser = {w_sat_out, w_ext_out};

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for clamped_cubic_hermite_interp_2d: directed and random items
// against a bit-exact hermite predictor, random stalls on both streams
// depends on chi2d_pkg and the rtl top level
module tb_top;
    import chi2d_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int PIPE_LATENCY = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASES       = 13;
    localparam int PHASE_ITEMS  = 150;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    localparam longint ALPHA_ONE = longint'(1) << FRAC_BITS;
    localparam longint ALPHA_LIM = longint'(3) << (FRAC_BITS - 1);

    localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
    localparam logic signed [127:0] SAT_LO = -SAT_HI - 128'sd1;

    // fields from the lowest bit up: prev_x, prev_y, prev_vx, prev_vy,
    // latest_x, latest_y, latest_vx, latest_vy, elapsed_us
    typedef struct packed {
        logic [DATA_W-1:0] elapsed_us;
        t_word             latest_vy;
        t_word             latest_vx;
        t_word             latest_y;
        t_word             latest_x;
        t_word             prev_vy;
        t_word             prev_vx;
        t_word             prev_y;
        t_word             prev_x;
    } t_snapshot_pair;

    // fields from the lowest bit up: out_x, out_y, extrapolating, saturated
    typedef struct packed {
        logic  saturated;
        logic  extrapolating;
        t_word out_y;
        t_word out_x;
    } t_interp_result;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [IN_FIELDS*DATA_W-1:0] s_tdata;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [2*DATA_W-1:0]        m_tdata;
    logic [1:0]                 m_tuser;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [DATA_W-1:0]          cfg_data;

    logic [DATA_W-1:0] alpha_rate_q    = ALPHA_RATE_RST;
    logic [TS_W-1:0]   tangent_scale_q = TANGENT_SCALE_RST;
    logic [DATA_W-1:0] world_scale_q   = WORLD_SCALE_RST;

    t_interp_result expected_positions[$];
    int             errors     = 0;
    int             stall_left = 0;
    logic           burst_mode = 1'b0;

    clamped_cubic_hermite_interp_2d #(
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    // one axis: tangents, hermite blend, world scaling with saturation
    function automatic t_word predict_axis(input t_word p0, v0, p1, v1,
                                           input longint h00, h10, h01, h11,
                                           output logic clipped);
        longint m0, m1, acc, blended;
        logic signed [127:0] wide_pos, wide_scale, scaled;
        m0 = (longint'(v0) * longint'(tangent_scale_q)) >>> TS_SHIFT;
        m1 = (longint'(v1) * longint'(tangent_scale_q)) >>> TS_SHIFT;
        acc = longint'(p0) * h00 + m0 * h10 + longint'(p1) * h01 + m1 * h11;
        blended = acc >>> FRAC_BITS;
        wide_pos = 128'(blended);
        wide_scale = {96'd0, world_scale_q};
        scaled = (wide_pos * wide_scale) >>> WS_FRAC;
        clipped = 1'b0;
        if (scaled > SAT_HI) begin
            clipped = 1'b1;
            return SAT_HI[DATA_W-1:0];
        end
        if (scaled < SAT_LO) begin
            clipped = 1'b1;
            return SAT_LO[DATA_W-1:0];
        end
        return scaled[DATA_W-1:0];
    endfunction

    function automatic t_interp_result predict_interp(input t_snapshot_pair item);
        longint unsigned alpha_prod;
        longint alpha, a2, a3, h00, h10, h01, h11;
        logic clip_x, clip_y;
        t_interp_result r;
        alpha_prod = 64'(item.elapsed_us) * 64'(alpha_rate_q);
        alpha = longint'(alpha_prod >> (DATA_W - FRAC_BITS));
        if (alpha > ALPHA_LIM)
            alpha = ALPHA_LIM;
        a2 = (alpha * alpha) >>> FRAC_BITS;
        a3 = (a2 * alpha) >>> FRAC_BITS;
        h00 = 2 * a3 - 3 * a2 + ALPHA_ONE;
        h10 = a3 - 2 * a2 + alpha;
        h01 = -2 * a3 + 3 * a2;
        h11 = a3 - a2;
        r.out_x = predict_axis(item.prev_x, item.prev_vx, item.latest_x, item.latest_vx,
                               h00, h10, h01, h11, clip_x);
        r.out_y = predict_axis(item.prev_y, item.prev_vy, item.latest_y, item.latest_vy,
                               h00, h10, h01, h11, clip_y);
        r.extrapolating = (alpha > ALPHA_ONE);
        r.saturated = clip_x | clip_y;
        return r;
    endfunction

    function automatic t_snapshot_pair make_item(input t_word px, py, pvx, pvy,
                                                 input t_word lx, ly, lvx, lvy,
                                                 input logic [DATA_W-1:0] el);
        t_snapshot_pair it;
        it.prev_x = px;     it.prev_y = py;
        it.prev_vx = pvx;   it.prev_vy = pvy;
        it.latest_x = lx;   it.latest_y = ly;
        it.latest_vx = lvx; it.latest_vy = lvy;
        it.elapsed_us = el;
        return it;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $signed($urandom) >>> $urandom_range(4, 24);
        endcase
    endfunction

    // mostly elapsed times that land alpha around the clamp region
    function automatic logic [DATA_W-1:0] rand_elapsed();
        longint unsigned span;
        span = (64'd7 << 30) / 64'(alpha_rate_q == 0 ? 32'd1 : alpha_rate_q);
        if ($urandom_range(0, 7) == 0 || span > 64'hFFFF_FFFF)
            return $urandom;
        return $urandom_range(0, span[DATA_W-1:0]);
    endfunction

    function automatic t_snapshot_pair rand_item();
        return make_item(rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_elapsed());
    endfunction

    function automatic logic [DATA_W-1:0] rand_alpha_rate();
        case ($urandom_range(0, 5))
            0: return 32'd1;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(20000, 400000);
            4: return $urandom_range(1, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_tangent_scale();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd65535;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_world_scale();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'd65536;
            3, 4: return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_snapshot_pair item);
        int gap;
        t_interp_result want;
        gap = burst_mode ? 0 : $urandom_range(0, 16);
        want = predict_interp(item);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= item;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_positions.push_back(want);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge clk);
        repeat (2 * PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_ALPHA_RATE:    alpha_rate_q = val;
            CFG_TANGENT_SCALE: tangent_scale_q = val[TS_W-1:0];
            CFG_WORLD_SCALE:   world_scale_q = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: a fresh stall is drawn after every result
    always @(negedge clk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_interp_result got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            stall_left <= burst_mode ? 0 : $urandom_range(0, 16);
            if (expected_positions.size() == 0) begin
                $display("%0t unexpected item: x %0d y %0d flags %b", $time,
                         got.out_x, got.out_y, m_tuser);
                errors++;
            end else begin
                want = expected_positions.pop_front();
                if (got.out_x !== want.out_x) begin
                    $display("%0t out_x expected %0d actual %0d", $time, want.out_x, got.out_x);
                    errors++;
                end
                if (got.out_y !== want.out_y) begin
                    $display("%0t out_y expected %0d actual %0d", $time, want.out_y, got.out_y);
                    errors++;
                end
                if (got.extrapolating !== want.extrapolating) begin
                    $display("%0t extrapolating expected %b actual %b", $time,
                             want.extrapolating, got.extrapolating);
                    errors++;
                end
                if (got.saturated !== want.saturated) begin
                    $display("%0t saturated expected %b actual %b", $time,
                             want.saturated, got.saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic test_reset_config();
        send_item(make_item(32'h0001_0000, -32'sh0002_0000, 32'h0010_0000, 32'h0,
                            32'h0005_0000, 32'h0003_0000, -32'sh0008_0000, 32'h0004_0000, 0));
        send_item(make_item(32'h0001_0000, -32'sh0002_0000, 32'h0010_0000, 32'h0,
                            32'h0005_0000, 32'h0003_0000, -32'sh0008_0000, 32'h0004_0000, 11642));
        send_item(make_item(-32'sh0100_0000, 32'h0200_0000, 32'h0,
                            -32'sh0001_0000, 32'h0120_0000, 32'h0210_0000,
                            32'h0300_0000, 32'h0, 60000));
        send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000,
                            32'h0005_0000, 32'h0006_0000, 32'h0007_0000, 32'h0008_0000,
                            32'hFFFF_FFFF));
    endtask

    task automatic test_field_extremes();
        send_item(make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'hFFFF_FFFF));
        send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'hFFFF_FFFF));
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        send_item(make_item(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0,
                            32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 30000));
    endtask

    task automatic test_alpha_rate();
        // zero rate keeps alpha at zero whatever the elapsed time
        write_reg(CFG_ALPHA_RATE, 32'd0);
        send_item(make_item(32'h0012_3456, -32'sh0065_4321, 32'h0100_0000, 32'h0,
                            32'h0777_0000, 32'h0, 32'h0, -32'sh0100_0000, 32'hFFFF_FFFF));
        send_item(rand_item());
        // unit rate walks alpha across one and onto the clamp
        write_reg(CFG_ALPHA_RATE, 32'h0001_0000);
        send_item(make_item(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                            32'h0010_0000, -32'sh0010_0000, 32'h0, 32'h0, 65536));
        send_item(make_item(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                            32'h0010_0000, -32'sh0010_0000, 32'h0, 32'h0, 65537));
        send_item(make_item(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                            32'h0010_0000, -32'sh0010_0000, 32'h0, 32'h0, 98304));
        send_item(make_item(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000,
                            32'h0010_0000, -32'sh0010_0000, 32'h0, 32'h0, 98305));
        write_reg(CFG_ALPHA_RATE, 32'hFFFF_FFFF);
        send_item(make_item(32'h0100_0000, 32'h0200_0000, 32'h0, 32'h0,
                            32'h0300_0000, 32'h0400_0000, 32'h0, 32'h0, 1));
        send_item(make_item(32'h0100_0000, 32'h0200_0000, 32'h0, 32'h0,
                            32'h0300_0000, 32'h0400_0000, 32'h0, 32'h0, 2));
    endtask

    task automatic test_scales();
        write_reg(CFG_ALPHA_RATE, ALPHA_RATE_RST);
        write_reg(CFG_TANGENT_SCALE, 32'd0);
        send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0003_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'h8000_0000, 30000));
        write_reg(CFG_TANGENT_SCALE, 32'd65535);
        send_item(make_item(32'h0001_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0003_0000, 32'h0004_0000, 32'h7FFF_FFFF, 32'h8000_0000, 30000));
        write_reg(CFG_WORLD_SCALE, 32'd0);
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'hFFFF_FFFF));
        write_reg(CFG_WORLD_SCALE, 32'hFFFF_FFFF);
        send_item(make_item(32'h0000_8000, -32'sh0000_8000, 32'h0, 32'h0,
                            32'h0000_8000, -32'sh0000_8000, 32'h0, 32'h0, 0));
        send_item(make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 0));
    endtask

    task automatic test_unused_index();
        write_reg(CFG_IDX_UNUSED, 32'h1234_5678);
        send_item(make_item(32'h0040_0000, -32'sh0040_0000, 32'h0008_0000, 32'h0,
                            32'h0050_0000, -32'sh0030_0000, 32'h0, 32'h0008_0000, 40000));
        write_reg(CFG_WORLD_SCALE, WORLD_SCALE_RST);
        write_reg(CFG_TANGENT_SCALE, TANGENT_SCALE_RST);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                if ($urandom_range(0, 1)) write_reg(CFG_ALPHA_RATE, rand_alpha_rate());
                if ($urandom_range(0, 1)) write_reg(CFG_TANGENT_SCALE, rand_tangent_scale());
                if ($urandom_range(0, 1)) write_reg(CFG_WORLD_SCALE, rand_world_scale());
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item());
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ALPHA_RATE;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_config();
        test_field_extremes();
        test_alpha_rate();
        test_scales();
        test_unused_index();
        test_random_phases();

        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
